[src/sgm_pkg.sv]
// Shared types and constants of the Sobel gradient magnitude unit.
package sgm_pkg;

   localparam int MAX_WIDTH_DEFAULT   = 1024;
   localparam int PIXEL_BITS_DEFAULT  = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;
   localparam int MAG_BITS        = 11;
   localparam int MAG_MAX         = 2047;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_CLAMP_EDGES  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_RUN  = 2'b10
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_SQUARE = 4'b0010,
      B_ROOT   = 4'b0100,
      B_DONE   = 4'b1000
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[src/sgm_queue.sv]
// Small register queue between the window front end and the magnitude back end.
module sgm_queue #(
   parameter int DATA_BITS = 73,
   parameter int DEPTH     = sgm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [DATA_BITS-1:0]     push_data,
   input  logic                     pop,
   output logic [DATA_BITS-1:0]     pop_data,
   output sgm_pkg::queue_status_type status
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] entry_ff [DEPTH];
   logic [PTR_BITS-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign status.full  = (32'(count_ff) == 32'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (32'(tail_ff) == DEPTH - 1) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (32'(head_ff) == DEPTH - 1) ? '0 : head_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

[src/sgm_front.sv]
// Front end: line stores, 3x3 window, raster counters and border selection.
module sgm_front #(
   parameter int MAX_WIDTH  = sgm_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS = sgm_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sgm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sgm_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 req_push,
   input  logic                                 req_opcode,
   input  logic [7:0]                           req_pixel,
   output logic                                 req_full,
   input  sgm_pkg::queue_status_type            q_status,
   output logic                                 q_push,
   output logic [9*PIXEL_BITS:0]                q_data
);

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WBITS     = $clog2(MAX_WIDTH + 1);
   localparam int PEND_BITS = $clog2(MAX_WIDTH + 2);
   localparam int HB        = sgm_pkg::HEIGHT_REG_BITS;

   sgm_pkg::front_state_type state_ff;

   logic [sgm_pkg::WIDTH_REG_BITS-1:0] width_ff;
   logic [HB-1:0]                      height_ff;
   logic                               clamp_ff;

   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] upper_rd_ff, lower_rd_ff;
   logic [PIXEL_BITS-1:0] win_ff [9];
   logic [PIXEL_BITS-1:0] win_in [9];
   logic [PIXEL_BITS-1:0] sel [9];

   logic                  opcode_ff;
   logic [PIXEL_BITS-1:0] pixel_ff;
   logic [COL_BITS-1:0]   addr_ff, rd_addr;
   logic [COL_BITS-1:0]   incol_ff, outcol_ff;
   logic [HB-1:0]         inrow_ff, outrow_ff;
   logic [PEND_BITS-1:0]  pend_ff;

   logic [WBITS-1:0] w;
   logic [HB-1:0]    h;
   logic             accept, running, restart;
   logic             drain_fire, pix_step, pix_emit, emit;
   logic             in_col_end, in_row_end, out_col_end, out_row_end;
   logic             vc [3];
   logic             vr [3];
   logic [31:0]      pend_plus;

   // Effective geometry: width saturated to 1..MAX_WIDTH, height zero read as one.
   always_comb begin
      if (width_ff == '0) begin
         w = WBITS'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w = WBITS'(MAX_WIDTH);
      end else begin
         w = WBITS'(width_ff);
      end
      h = (height_ff == '0) ? HB'(1) : height_ff;
   end

   assign req_full = (state_ff != sgm_pkg::F_IDLE) || q_status.full;
   assign accept   = req_push && !req_full;
   assign running  = (state_ff == sgm_pkg::F_RUN);
   assign restart  = csr_write_enable &&
                     ((csr_index == sgm_pkg::REG_IMAGE_WIDTH) ||
                      (csr_index == sgm_pkg::REG_IMAGE_HEIGHT));

   assign in_col_end  = (32'(incol_ff) + 1 >= 32'(w));
   assign in_row_end  = (32'(inrow_ff) + 1 >= 32'(h));
   assign out_col_end = (32'(outcol_ff) + 1 >= 32'(w));
   assign out_row_end = (32'(outrow_ff) + 1 >= 32'(h));

   // A drain reads the column just ahead of the output position.
   always_comb begin
      if (req_opcode) begin
         rd_addr = out_col_end ? '0 : COL_BITS'(32'(outcol_ff) + 1);
      end else begin
         rd_addr = incol_ff;
      end
   end

   assign drain_fire = running && opcode_ff && (incol_ff == '0) && (inrow_ff == '0) &&
                       (pend_ff != '0);
   assign pix_step   = running && !opcode_ff;
   assign pend_plus  = 32'(pend_ff) + 1;
   assign pix_emit   = pix_step && (pend_plus > 32'(w) + 1);
   assign emit       = drain_fire || pix_emit;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         win_in[k] = win_ff[k+3];
      end
      win_in[6] = upper_rd_ff;
      win_in[7] = lower_rd_ff;
      win_in[8] = opcode_ff ? '0 : pixel_ff;
   end

   // Border handling on the shifted window: column i, row j.
   always_comb begin
      vc[0] = (outcol_ff != '0);
      vc[1] = 1'b1;
      vc[2] = !out_col_end;
      vr[0] = (outrow_ff != '0);
      vr[1] = 1'b1;
      vr[2] = !out_row_end;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (!clamp_ff && (!vc[i] || !vr[j])) begin
               sel[i*3+j] = '0;
            end else begin
               sel[i*3+j] = win_in[(vc[i] ? i : 1) * 3 + (vr[j] ? j : 1)];
            end
         end
      end
   end

   always_comb begin
      q_data = '0;
      for (int k = 0; k < 9; k++) begin
         q_data[k*PIXEL_BITS +: PIXEL_BITS] = sel[k];
      end
      q_data[9*PIXEL_BITS] = out_row_end && out_col_end;
   end
   assign q_push = emit;

   // Line stores: read on accept, write back once the read data is in.
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff <= upper_mem[rd_addr];
         lower_rd_ff <= lower_mem[rd_addr];
      end
      if (pix_step) begin
         upper_mem[addr_ff] <= lower_rd_ff;
         lower_mem[addr_ff] <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= req_opcode;
         pixel_ff  <= PIXEL_BITS'(req_pixel);
         addr_ff   <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sgm_pkg::F_IDLE;
         width_ff  <= sgm_pkg::WIDTH_REG_BITS'(1024);
         height_ff <= HB'(1024);
         clamp_ff  <= 1'b1;
         incol_ff  <= '0;
         inrow_ff  <= '0;
         outcol_ff <= '0;
         outrow_ff <= '0;
         pend_ff   <= '0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         case (state_ff)
            sgm_pkg::F_IDLE: if (accept) state_ff <= sgm_pkg::F_RUN;
            sgm_pkg::F_RUN:  state_ff <= sgm_pkg::F_IDLE;
            default:         state_ff <= sgm_pkg::F_IDLE;
         endcase

         if (csr_write_enable) begin
            case (csr_index)
               sgm_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data[sgm_pkg::WIDTH_REG_BITS-1:0];
               sgm_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data[HB-1:0];
               sgm_pkg::REG_CLAMP_EDGES:  clamp_ff  <= csr_data[0];
               default: ;
            endcase
         end

         if (drain_fire || pix_step) begin
            for (int k = 0; k < 9; k++) begin
               win_ff[k] <= win_in[k];
            end
         end

         if (restart) begin
            incol_ff  <= '0;
            inrow_ff  <= '0;
            outcol_ff <= '0;
            outrow_ff <= '0;
            pend_ff   <= '0;
         end else begin
            if (pix_step) begin
               if (in_col_end) begin
                  incol_ff <= '0;
                  inrow_ff <= in_row_end ? '0 : inrow_ff + 1'b1;
               end else begin
                  incol_ff <= incol_ff + 1'b1;
               end
               pend_ff <= PEND_BITS'(pend_plus - (pix_emit ? 32'd1 : 32'd0));
            end else if (drain_fire) begin
               pend_ff <= pend_ff - 1'b1;
            end
            if (emit) begin
               if (out_col_end) begin
                  outcol_ff <= '0;
                  outrow_ff <= out_row_end ? '0 : outrow_ff + 1'b1;
               end else begin
                  outcol_ff <= outcol_ff + 1'b1;
               end
            end
         end
      end
   end

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pend_ff) <= 32'(w) + 1)
      else $error("pending count above width plus one");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("result pushed into a full queue");

   a_run_once: assert property (@(posedge clock) disable iff (reset)
      running |=> (state_ff == sgm_pkg::F_IDLE))
      else $error("front end stayed in run phase");

endmodule

[src/sgm_back.sv]
// Back end: Sobel gradients, sum of squares and a bit-serial integer square root.
module sgm_back #(
   parameter int PIXEL_BITS = sgm_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sgm_pkg::queue_status_type         q_status,
   input  logic [9*PIXEL_BITS:0]             q_data,
   output logic                              q_pop,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [sgm_pkg::MAG_BITS-1:0]      rsp_magnitude,
   output logic                              rsp_last_of_frame
);

   localparam int GB       = PIXEL_BITS + 4;
   localparam int NB       = PIXEL_BITS + 3;
   localparam int SQ_BITS  = 2 * NB;
   localparam int CNT_BITS = $clog2(NB + 1);

   sgm_pkg::back_state_type state_ff;

   logic signed [GB-1:0]   gx_ff, gy_ff, gx_in, gy_in;
   logic signed [2*GB-1:0] sqx, sqy;
   logic [SQ_BITS-1:0]     op_ff;
   logic [NB:0]            rem_ff, rem_in;
   logic [NB-1:0]          root_ff, root_in;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic                   last_ff;
   logic [NB+2:0]          rem_sh, trial;

   always_comb begin
      logic signed [GB-1:0] p [9];
      for (int k = 0; k < 9; k++) begin
         p[k] = GB'($signed({4'b0, q_data[k*PIXEL_BITS +: PIXEL_BITS]}));
      end
      gx_in = GB'((p[6] - p[0]) + 2 * (p[7] - p[1]) + (p[8] - p[2]));
      gy_in = GB'((p[2] - p[0]) + 2 * (p[5] - p[3]) + (p[8] - p[6]));
   end

   assign sqx = gx_ff * gx_ff;
   assign sqy = gy_ff * gy_ff;

   // One result bit a step, most significant first.
   always_comb begin
      rem_sh = {rem_ff, op_ff[SQ_BITS-1 -: 2]};
      trial  = (NB+3)'({root_ff, 2'b01});
      if (rem_sh >= trial) begin
         rem_in  = (NB+1)'(rem_sh - trial);
         root_in = {root_ff[NB-2:0], 1'b1};
      end else begin
         rem_in  = (NB+1)'(rem_sh);
         root_in = {root_ff[NB-2:0], 1'b0};
      end
   end

   assign q_pop     = (state_ff == sgm_pkg::B_IDLE) && !q_status.empty;
   assign rsp_empty = (state_ff != sgm_pkg::B_DONE);
   assign rsp_last_of_frame = last_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         last_ff <= q_data[9*PIXEL_BITS];
      end
      if (state_ff == sgm_pkg::B_SQUARE) begin
         op_ff   <= SQ_BITS'($unsigned(sqx)) + SQ_BITS'($unsigned(sqy));
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (state_ff == sgm_pkg::B_ROOT) begin
         op_ff   <= {op_ff[SQ_BITS-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         if (32'(cnt_ff) == NB - 1) begin
            rsp_magnitude <= (32'(root_in) > sgm_pkg::MAG_MAX) ?
                             sgm_pkg::MAG_BITS'(sgm_pkg::MAG_MAX) :
                             sgm_pkg::MAG_BITS'(root_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgm_pkg::B_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            sgm_pkg::B_IDLE: begin
               if (q_pop) state_ff <= sgm_pkg::B_SQUARE;
            end
            sgm_pkg::B_SQUARE: begin
               cnt_ff   <= '0;
               state_ff <= sgm_pkg::B_ROOT;
            end
            sgm_pkg::B_ROOT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (32'(cnt_ff) == NB - 1) state_ff <= sgm_pkg::B_DONE;
            end
            sgm_pkg::B_DONE: begin
               if (rsp_pop) state_ff <= sgm_pkg::B_IDLE;
            end
            default: state_ff <= sgm_pkg::B_IDLE;
         endcase
      end
   end

endmodule

[src/sobel_gradient_magnitude_unit.sv]
// Top level of the streaming 3x3 Sobel gradient magnitude unit.
// Pixels enter in raster order, one request per pixel; results leave in raster order
// one row and one pixel behind, and drain requests after a frame flush the rest. The
// front end reads the line stores for a request, then updates the window, and takes
// no new request until then or while the queue is full. Each result then passes
// through the back end (gradients, squares, and a square root that yields one bit per
// cycle) and is held there until popped; only then is a new window taken. A queue of
// QUEUE_DEPTH window snapshots lets the front end run ahead of the back end.
module sobel_gradient_magnitude_unit #(
   parameter int MAX_WIDTH   = sgm_pkg::MAX_WIDTH_DEFAULT,
   parameter int PIXEL_BITS  = sgm_pkg::PIXEL_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = sgm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [sgm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sgm_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_opcode,
   input  logic [7:0]                         req_pixel,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [sgm_pkg::MAG_BITS-1:0]       rsp_magnitude,
   output logic                               rsp_last_of_frame
);

   localparam int TASK_BITS = 9 * PIXEL_BITS + 1;

   sgm_pkg::queue_status_type q_status;
   logic                      q_push, q_pop;
   logic [TASK_BITS-1:0]      q_push_data, q_pop_data;

   sgm_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_push         (req_push),
      .req_opcode       (req_opcode),
      .req_pixel        (req_pixel),
      .req_full         (req_full),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   sgm_queue #(
      .DATA_BITS (TASK_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   sgm_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_data            (q_pop_data),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
